// ===== sv/rsm_pkg.sv =====
// Shared constants, types and controller/datapath interface structs for the mapper.
package rsm_pkg;

    localparam int MAX_CHILDREN = 8;
    localparam int MAX_REQUEST  = 64;
    localparam int STRIPE_MAX   = 4096;

    localparam int SECTOR_W = 48;
    localparam int COUNT_W  = 7;
    localparam int CHILD_W  = 3;
    localparam int STRIPE_W = 13;
    localparam int NCH_W    = 4;
    localparam int CTR_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NCHILD = 2'd2;

    localparam logic MODE_STRIPE = 1'b0;
    localparam logic MODE_MIRROR = 1'b1;

    typedef enum logic [1:0] {
        DIV_SECTOR,
        DIV_CHUNK,
        DIV_COUNTER
    } div_sel_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_SPECIAL,
        EMIT_STRIPE,
        EMIT_MIRROR
    } emit_kind_t;

    typedef struct packed {
        logic       load;
        logic       div_go;
        div_sel_t   div_sel;
        logic       take_sec;
        logic       take_chk;
        logic       take_ctr;
        logic       mult;
        emit_kind_t emit;
        logic       seg_adv;
        logic       mirr_adv;
        logic       ctr_inc;
    } rsm_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic cnt_zero;
        logic mirror;
        logic wr;
        logic div_done;
        logic out_free;
        logic seg_last;
        logic seg_wrap;
        logic mirr_last;
    } rsm_stat_t;

endpackage

// ===== sv/raid_stripe_mirror_mapper.sv =====
// Top level of the striping / mirroring child-command mapper.
//
//  channel  | direction | handshake              | payload
//  s_       | in        | s_tvalid / s_tready    | s_tdata, s_tuser
//  m_       | out       | m_tvalid / m_tready    | m_tdata, m_tuser, m_tlast
//  cfg_     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One request at a time. Stripe mode: two bit-serial divisions (by chunk size
//  and by child count) and one multiply before the first word, then one word per
//  cycle; a segment whose start wraps past the top of the address space reruns
//  both divisions. Mirror read: one division of the read counter, mirror write:
//  one word per child per cycle.
//  aresetn is synchronous; m_tready low holds the result word and stalls the sequence.
module raid_stripe_mirror_mapper (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [55:0]                     s_tdata,  // start_sector[47:0], nsectors[54:48]
    input  logic                            s_tuser,  // cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [71:0]                     m_tdata,  // child_index[2:0], dev_sector[50:3],
                                                      // seg_length[57:51], buffer_offset[64:58]
    output logic [1:0]                      m_tuser,  // is_write[0], status[1]
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rsm_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import rsm_pkg::*;

    rsm_cmd_t            cmd;
    rsm_stat_t           stat;
    logic [CHILD_W-1:0]  o_child;
    logic [SECTOR_W-1:0] o_sector;
    logic [COUNT_W-1:0]  o_len;
    logic [COUNT_W-1:0]  o_boff;
    logic                o_wr;
    logic                o_status;

    assign cfg_ready = 1'b1;

    rsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rsm_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_cmd     (s_tuser),
        .in_start   (s_tdata[47:0]),
        .in_count   (s_tdata[54:48]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_child  (o_child),
        .out_sector (o_sector),
        .out_len    (o_len),
        .out_boff   (o_boff),
        .out_wr     (o_wr),
        .out_status (o_status),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'b0, o_boff, o_len, o_sector, o_child};
    assign m_tuser = {o_status, o_wr};

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("error word not marked last");

    a_status_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[57:51] == 7'd0)
        else $error("error word carries a length");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[57:51] <= 7'd64)
        else $error("segment length above request limit");

endmodule

// ===== sv/rsm_div.sv =====
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 13-bit divisor.
module rsm_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             go,
    input  logic [rsm_pkg::SECTOR_W-1:0]     dividend,
    input  logic [rsm_pkg::STRIPE_W-1:0]     divisor,
    output logic                             done,
    output logic [rsm_pkg::SECTOR_W-1:0]     quot,
    output logic [rsm_pkg::STRIPE_W-1:0]     rem
);
    import rsm_pkg::*;

    localparam int CNT_W = $clog2(SECTOR_W);

    logic [SECTOR_W-1:0] quot_reg, quot_next;
    logic [STRIPE_W-1:0] rem_reg, rem_next;
    logic [STRIPE_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STRIPE_W:0]   trial;
    logic                fits;

    assign trial = {rem_reg, quot_reg[SECTOR_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (go) begin
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(SECTOR_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quot_next = {quot_reg[SECTOR_W-2:0], fits};
            rem_next  = fits ? STRIPE_W'(trial - {1'b0, dsr_reg}) : trial[STRIPE_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ===== sv/rsm_datapath.sv =====
// Datapath: configuration, request registers, address arithmetic and result register.
module rsm_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rsm_pkg::rsm_cmd_t                   cmd,
    output rsm_pkg::rsm_stat_t                  stat,
    input  logic                                cfg_valid,
    input  logic [rsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsm_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  logic                                in_cmd,
    input  logic [rsm_pkg::SECTOR_W-1:0]        in_start,
    input  logic [rsm_pkg::COUNT_W-1:0]         in_count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rsm_pkg::CHILD_W-1:0]         out_child,
    output logic [rsm_pkg::SECTOR_W-1:0]        out_sector,
    output logic [rsm_pkg::COUNT_W-1:0]         out_len,
    output logic [rsm_pkg::COUNT_W-1:0]         out_boff,
    output logic                                out_wr,
    output logic                                out_status,
    output logic                                out_last
);
    import rsm_pkg::*;

    logic                mode_reg;
    logic [STRIPE_W-1:0] stripe_reg;
    logic [NCH_W-1:0]    nch_reg;
    logic [CTR_W-1:0]    ctr_reg;

    logic                wr_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  done_reg;
    logic [SECTOR_W-1:0] sec_reg;
    logic [SECTOR_W-1:0] row_reg;
    logic [STRIPE_W-1:0] off_reg;
    logic [CHILD_W-1:0]  child_reg;
    logic [SECTOR_W-1:0] base_reg;
    logic [CHILD_W-1:0]  mi_reg;

    logic                ov_reg;
    logic [CHILD_W-1:0]  oc_reg;
    logic [SECTOR_W-1:0] os_reg;
    logic [COUNT_W-1:0]  ol_reg;
    logic [COUNT_W-1:0]  ob_reg;
    logic                ow_reg;
    logic                ost_reg;
    logic                olast_reg;

    logic [NCH_W-1:0]    n_eff;
    logic [STRIPE_W-1:0] cs_eff;
    logic [COUNT_W-1:0]  cnt_sat;
    logic [COUNT_W-1:0]  remain;
    logic [STRIPE_W-1:0] avail;
    logic [COUNT_W-1:0]  seg_len;
    logic [SECTOR_W:0]   nsum;
    logic                child_wrap;

    logic                div_done;
    logic [SECTOR_W-1:0] div_quot;
    logic [STRIPE_W-1:0] div_rem;
    logic [SECTOR_W-1:0] div_a;
    logic [STRIPE_W-1:0] div_b;

    assign n_eff  = (nch_reg > NCH_W'(MAX_CHILDREN)) ? NCH_W'(MAX_CHILDREN) : nch_reg;
    assign cs_eff = (stripe_reg == '0) ? STRIPE_W'(1) :
                    (stripe_reg > STRIPE_W'(STRIPE_MAX)) ? STRIPE_W'(STRIPE_MAX) : stripe_reg;
    assign cnt_sat = (in_count > COUNT_W'(MAX_REQUEST)) ? COUNT_W'(MAX_REQUEST) : in_count;

    assign remain  = count_reg - done_reg;
    assign avail   = cs_eff - off_reg;
    assign seg_len = ({{(STRIPE_W-COUNT_W){1'b0}}, remain} > avail) ?
                     avail[COUNT_W-1:0] : remain;
    assign nsum    = {1'b0, sec_reg} + {{(SECTOR_W+1-COUNT_W){1'b0}}, seg_len};
    assign child_wrap = ({1'b0, child_reg} + 1'b1) == n_eff;

    always_comb begin
        case (cmd.div_sel)
            DIV_SECTOR: begin
                div_a = sec_reg;
                div_b = cs_eff;
            end
            DIV_CHUNK: begin
                div_a = row_reg;
                div_b = {{(STRIPE_W-NCH_W){1'b0}}, n_eff};
            end
            DIV_COUNTER: begin
                div_a = {{(SECTOR_W-CTR_W){1'b0}}, ctr_reg};
                div_b = {{(STRIPE_W-NCH_W){1'b0}}, n_eff};
            end
            default: begin
                div_a = sec_reg;
                div_b = cs_eff;
            end
        endcase
    end

    rsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (cmd.div_go),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb begin
        stat.n_zero    = (nch_reg == '0);
        stat.cnt_zero  = (count_reg == '0);
        stat.mirror    = (mode_reg == MODE_MIRROR);
        stat.wr        = wr_reg;
        stat.div_done  = div_done;
        stat.out_free  = !ov_reg || out_ready;
        stat.seg_last  = (seg_len == remain);
        stat.seg_wrap  = nsum[SECTOR_W];
        stat.mirr_last = ({1'b0, mi_reg} + 1'b1) == n_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_STRIPE;
            stripe_reg <= STRIPE_W'(128);
            nch_reg    <= '0;
            ctr_reg    <= '0;
            ov_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    REG_STRIPE: stripe_reg <= cfg_data;
                    REG_NCHILD: nch_reg    <= cfg_data[NCH_W-1:0];
                    default:    ;
                endcase
            end
            if (cmd.ctr_inc) begin
                ctr_reg <= ctr_reg + 1'b1;
            end
            if (cmd.emit != EMIT_NONE) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            wr_reg    <= in_cmd;
            count_reg <= cnt_sat;
            done_reg  <= '0;
            sec_reg   <= in_start;
            mi_reg    <= '0;
        end
        if (cmd.take_sec) begin
            row_reg <= div_quot;
            off_reg <= div_rem;
        end
        if (cmd.take_chk) begin
            row_reg   <= div_quot;
            child_reg <= div_rem[CHILD_W-1:0];
        end
        if (cmd.take_ctr) begin
            mi_reg <= div_rem[CHILD_W-1:0];
        end
        if (cmd.mult) begin
            base_reg <= SECTOR_W'(row_reg * cs_eff);
        end
        if (cmd.seg_adv) begin
            done_reg <= done_reg + seg_len;
            sec_reg  <= nsum[SECTOR_W-1:0];
            off_reg  <= '0;
            if (child_wrap) begin
                child_reg <= '0;
                base_reg  <= base_reg + {{(SECTOR_W-STRIPE_W){1'b0}}, cs_eff};
            end else begin
                child_reg <= child_reg + 1'b1;
            end
        end
        if (cmd.mirr_adv) begin
            mi_reg <= mi_reg + 1'b1;
        end
        case (cmd.emit)
            EMIT_SPECIAL: begin
                oc_reg    <= '0;
                os_reg    <= '0;
                ol_reg    <= '0;
                ob_reg    <= '0;
                ow_reg    <= wr_reg;
                ost_reg   <= (nch_reg == '0);
                olast_reg <= 1'b1;
            end
            EMIT_STRIPE: begin
                oc_reg    <= child_reg;
                os_reg    <= base_reg + {{(SECTOR_W-STRIPE_W){1'b0}}, off_reg};
                ol_reg    <= seg_len;
                ob_reg    <= done_reg;
                ow_reg    <= wr_reg;
                ost_reg   <= 1'b0;
                olast_reg <= (seg_len == remain);
            end
            EMIT_MIRROR: begin
                oc_reg    <= mi_reg;
                os_reg    <= sec_reg;
                ol_reg    <= count_reg;
                ob_reg    <= '0;
                ow_reg    <= wr_reg;
                ost_reg   <= 1'b0;
                olast_reg <= !wr_reg || (({1'b0, mi_reg} + 1'b1) == n_eff);
            end
            default: ;
        endcase
    end

    assign out_valid  = ov_reg;
    assign out_child  = oc_reg;
    assign out_sector = os_reg;
    assign out_len    = ol_reg;
    assign out_boff   = ob_reg;
    assign out_wr     = ow_reg;
    assign out_status = ost_reg;
    assign out_last   = olast_reg;

endmodule

// ===== sv/rsm_ctrl.sv =====
// Controller state machine sequencing divisions and result words per request.
module rsm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rsm_pkg::rsm_stat_t   stat,
    output rsm_pkg::rsm_cmd_t    cmd
);
    import rsm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV_SEC,
        ST_WAIT_SEC,
        ST_DIV_CHK,
        ST_WAIT_CHK,
        ST_MULT,
        ST_SEG,
        ST_MWAIT,
        ST_MIRR,
        ST_SINGLE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.div_sel  = DIV_SECTOR;
        cmd.emit     = EMIT_NONE;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.n_zero || stat.cnt_zero) begin
                    state_next = ST_SINGLE;
                end else if (stat.mirror) begin
                    if (stat.wr) begin
                        state_next = ST_MIRR;
                    end else begin
                        cmd.div_go  = 1'b1;
                        cmd.div_sel = DIV_COUNTER;
                        state_next  = ST_MWAIT;
                    end
                end else begin
                    state_next = ST_DIV_SEC;
                end
            end
            ST_DIV_SEC: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_SECTOR;
                state_next  = ST_WAIT_SEC;
            end
            ST_WAIT_SEC: begin
                if (stat.div_done) begin
                    cmd.take_sec = 1'b1;
                    state_next   = ST_DIV_CHK;
                end
            end
            ST_DIV_CHK: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_CHUNK;
                state_next  = ST_WAIT_CHK;
            end
            ST_WAIT_CHK: begin
                cmd.div_sel = DIV_CHUNK;
                if (stat.div_done) begin
                    cmd.take_chk = 1'b1;
                    state_next   = ST_MULT;
                end
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_SEG;
            end
            ST_SEG: begin
                if (stat.out_free) begin
                    cmd.emit    = EMIT_STRIPE;
                    cmd.seg_adv = 1'b1;
                    if (stat.seg_last) begin
                        state_next = ST_IDLE;
                    end else if (stat.seg_wrap) begin
                        state_next = ST_DIV_SEC;
                    end
                end
            end
            ST_MWAIT: begin
                cmd.div_sel = DIV_COUNTER;
                if (stat.div_done) begin
                    cmd.take_ctr = 1'b1;
                    state_next   = ST_MIRR;
                end
            end
            ST_MIRR: begin
                if (stat.out_free) begin
                    cmd.emit = EMIT_MIRROR;
                    if (!stat.wr) begin
                        cmd.ctr_inc = 1'b1;
                        state_next  = ST_IDLE;
                    end else if (stat.mirr_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.mirr_adv = 1'b1;
                    end
                end
            end
            ST_SINGLE: begin
                if (stat.out_free) begin
                    cmd.emit   = EMIT_SPECIAL;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== verif/tb_raid_stripe_mirror_mapper.sv =====
// Self-checking testbench for the striping / mirroring child-command mapper.
`timescale 1ns / 100ps

module tb_raid_stripe_mirror_mapper;
    import rsm_pkg::*;

    typedef struct packed {
        logic        wr;
        logic [47:0] start;
        logic [6:0]  count;
    } request_t;

    typedef struct packed {
        logic [2:0]  child;
        logic [47:0] csec;
        logic [6:0]  len;
        logic [6:0]  boff;
        logic        wr;
        logic        status;
        logic        last;
    } child_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    request_t   pending_reqs[$];
    child_cmd_t expected_cmds[$];
    logic       cur_mode;
    int unsigned cur_stripe, cur_nchild;
    logic [31:0] read_rr;
    int errors = 0;
    int words_seen = 0;
    int reqs_sent = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_phase = 0;

    raid_stripe_mirror_mapper i_dut (.*);

    always #5 aclk = ~aclk;

    function automatic child_cmd_t mk(logic [2:0] c, logic [47:0] s, logic [6:0] l,
                                      logic [6:0] b, logic w, logic st, logic la);
        child_cmd_t r;
        r = '{c, s, l, b, w, st, la};
        return r;
    endfunction

    task automatic map_request(request_t rq);
        longint unsigned n, cs, cnt, done, sec, chunk, off, len;
        n = cur_nchild;
        cs = cur_stripe;
        cnt = rq.count;
        done = 0;
        if (n == 0) begin
            expected_cmds.push_back(mk('0, '0, '0, '0, rq.wr, 1'b1, 1'b1));
            return;
        end
        if (n > MAX_CHILDREN) n = MAX_CHILDREN;
        if (cnt > MAX_REQUEST) cnt = MAX_REQUEST;
        if (cnt == 0) begin
            expected_cmds.push_back(mk('0, '0, '0, '0, rq.wr, 1'b0, 1'b1));
            return;
        end
        if (cs == 0) cs = 1;
        if (cs > STRIPE_MAX) cs = STRIPE_MAX;
        if (cur_mode == MODE_MIRROR) begin
            if (!rq.wr) begin
                expected_cmds.push_back(mk(3'(read_rr % n), rq.start, 7'(cnt), '0,
                                           1'b0, 1'b0, 1'b1));
                read_rr = read_rr + 1;
            end else begin
                for (longint unsigned i = 0; i < n; i++)
                    expected_cmds.push_back(mk(3'(i), rq.start, 7'(cnt), '0, 1'b1, 1'b0,
                                               i + 1 == n));
            end
            return;
        end
        while (done < cnt) begin
            sec = (rq.start + done) & 48'hFFFF_FFFF_FFFF;
            chunk = sec / cs;
            off = sec % cs;
            len = cnt - done;
            if (len > cs - off) len = cs - off;
            expected_cmds.push_back(mk(3'(chunk % n), 48'((chunk / n) * cs + off), 7'(len),
                                       7'(done), rq.wr, 1'b0, done + len >= cnt));
            done += len;
        end
    endtask

    // driver: bursts with random gaps
    always @(posedge aclk) begin
        int burst_n;
        burst_n = burst_left;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                reqs_sent <= reqs_sent + 1;
                burst_n = burst_left - 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && gap_left == 0 &&
                    !(s_tvalid && s_tready && burst_left <= 1)) begin
                    request_t rq;
                    rq = pending_reqs.pop_front();
                    map_request(rq);
                    s_tvalid <= 1'b1;
                    s_tdata <= {1'b0, rq.count, rq.start};
                    s_tuser <= rq.wr;
                end else begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                    else if (burst_left <= 1) begin
                        burst_n = $urandom_range(1, 6);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                    end
                end
            end
            burst_left <= burst_n;
        end
    end

    // monitor and receiver stall pattern
    always @(posedge aclk) begin
        if (aresetn) begin
            stall_phase <= (stall_phase + 1) % 97;
            m_tready <= (stall_phase < 40) ? 1'b1 :
                        (stall_phase < 70) ? ($urandom_range(0, 3) != 0) :
                        ($urandom_range(0, 1) == 1);
            if (m_tvalid && m_tready) begin
                child_cmd_t got, want;
                got = mk(m_tdata[2:0], m_tdata[50:3], m_tdata[57:51], m_tdata[64:58],
                         m_tuser[0], m_tuser[1], m_tlast);
                words_seen <= words_seen + 1;
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected word %p", $time, got);
                    errors <= errors + 1;
                end else begin
                    want = expected_cmds.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DAT_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODE:   cur_mode = val[0];
            REG_STRIPE: cur_stripe = val & 13'h1FFF;
            default:    cur_nchild = val & 4'hF;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || expected_cmds.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic request_t rand_req(int unsigned stripe);
        request_t rq;
        rq.wr = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: rq.start = 48'({$urandom, $urandom});
            1: rq.start = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 80);
            default: rq.start = 48'((stripe == 0 ? 0 : $urandom_range(0, 20) * stripe) +
                                    $urandom_range(0, 2 * stripe + 3));
        endcase
        rq.count = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) :
                                                     $urandom_range(0, 64));
        return rq;
    endfunction

    initial begin
        int unsigned modes[6] = '{0, 0, 1, 0, 1, 0};
        int unsigned stripes[6] = '{1, 4096, 8, 0, 5, 8191};
        int unsigned kids[6] = '{8, 3, 8, 15, 1, 2};
        cur_mode = MODE_STRIPE;
        cur_stripe = 128;
        cur_nchild = 0;
        read_rr = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // no children, reset config
        pending_reqs.push_back('{1'b0, 48'd5, 7'd3});
        pending_reqs.push_back('{1'b1, 48'd0, 7'd0});
        drain();
        write_reg(REG_NCHILD, 4);
        pending_reqs.push_back('{1'b0, 48'd0, 7'd0});
        pending_reqs.push_back('{1'b1, 48'd120, 7'd64});
        pending_reqs.push_back('{1'b0, 48'hFFFF_FFFF_FFFF, 7'd127});
        pending_reqs.push_back('{1'b1, 48'hFFFF_FFFF_FFC0, 7'd100});
        pending_reqs.push_back('{1'b0, 48'h5555_5555_5555, 7'd1});
        pending_reqs.push_back('{1'b1, 48'hAAAA_AAAA_AAAA, 7'd42});
        drain();
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_MODE, modes[p]);
            write_reg(REG_STRIPE, stripes[p]);
            write_reg(REG_NCHILD, kids[p]);
            for (int i = 0; i < 27; i++) pending_reqs.push_back(rand_req(stripes[p]));
            drain();
        end
        $display("Covered %0d requests and %0d child words over stripe and mirror settings,",
                 reqs_sent, words_seen);
        $display("including no children, zero and oversized counts, and address wrap.");
        if (errors == 0) begin
            $display("tb_raid_stripe_mirror_mapper: done, clean");
        end else begin
            $display("tb_raid_stripe_mirror_mapper: done, errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_raid_stripe_mirror_mapper: done, errors");
        $finish;
    end

endmodule
